// File: src/l1bp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l1bp_pkg
// Shared constants and types for the L1 ball projection block.
// ----------------------------------------------------------------------------
package l1bp_pkg;

	localparam int MaxElements = 64;
	localparam int IdxW        = $clog2(MaxElements);
	localparam int CntW        = $clog2(MaxElements + 1);
	localparam int SampleW     = 16;
	localparam int MagW        = 17;
	localparam int RadiusW     = 22;
	localparam int SumW        = MagW + CntW;
	localparam logic [RadiusW-1:0] RadiusReset = RadiusW'(256);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SCAN_RD,
		ST_SCAN,
		ST_DIV,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	// requests from the controller to the divider
	typedef struct packed {
		logic            start;
		logic [SumW-1:0] dividend;
		logic [CntW-1:0] divisor;
	} div_req_t;

	function automatic logic [MagW-1:0] mag_of(input logic [SampleW-1:0] raw);
		logic [MagW-1:0] r;
		begin
			r = raw[SampleW-1] ? (MagW'(0) - {1'b1, raw}) : {1'b0, raw};
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// File: src/l1bp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l1bp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module l1bp_div (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire l1bp_pkg::div_req_t    req,
	output logic                       done,
	output logic [l1bp_pkg::SumW-1:0]  quotient
);
	localparam int W = l1bp_pkg::SumW;
	localparam int BW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q;
	logic [l1bp_pkg::CntW-1:0] den_q;
	logic [BW-1:0] bit_q;
	logic          busy_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {{(W+1-l1bp_pkg::CntW){1'b0}}, den_q};

	// shift-subtract iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			bit_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				bit_q  <= BW'(W);
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == BW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

// File: src/l1bp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l1bp_ram
// Single-port-write, single-read synchronous memory, registered read data.
// ----------------------------------------------------------------------------
module l1bp_ram #(
	parameter int Depth = 64,
	parameter int Width = 16
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(Depth)-1:0]   waddr,
	input  wire [Width-1:0]           wdata,
	input  wire [$clog2(Depth)-1:0]   raddr,
	output logic [Width-1:0]          rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/l1_ball_projection_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l1_ball_projection_top
// Sort-based projection of a stored vector onto the L1 ball.
// ----------------------------------------------------------------------------
// Channel   | Direction | Handshake             | Payload
// input     | in        | start / busy          | sample, end_of_vector
// result    | out       | result_valid (strobe) | projected, final_item, overflowed
// config    | in        | cfg_valid / cfg_ready | cfg_data (radius)
//
// Loading stores each accepted sample. On the closing sample the block sorts
// the magnitudes in a second memory by insertion: it fetches each key, then
// compares and shifts smaller entries up until the key's place is found, or
// places the key at the front; it then scans the sorted magnitudes, divides
// and emits the results, each waiting for its sample's memory read.
// Reset is asynchronous; memories need none. Results cannot be stalled.
// ----------------------------------------------------------------------------
module l1_ball_projection_top (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire signed [15:0]                  sample,
	input  wire                                end_of_vector,
	output logic                               result_valid,
	output logic signed [15:0]                 projected,
	output logic                               final_item,
	output logic                               overflowed,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [21:0]                         cfg_data
);
	localparam int IdxW = l1bp_pkg::IdxW;
	localparam int CntW = l1bp_pkg::CntW;
	localparam int MagW = l1bp_pkg::MagW;
	localparam int SumW = l1bp_pkg::SumW;

	l1bp_pkg::state_t state_q, state_d;
	logic [l1bp_pkg::RadiusW-1:0] radius_q;
	logic [CntW-1:0] count_q;
	logic            ovf_q;
	logic [CntW-1:0] i_q, j_q;       // outer / inner sort indices, scan/emit index
	logic [MagW-1:0] key_q;
	logic            key_ld_q;       // key of the current insertion is held
	logic [SumW-1:0] sum_q, sum_rho_q;
	logic [CntW-1:0] rho_q;
	logic [SumW-1:0] theta_q;
	logic            accept;

	// sample store
	logic            s_we;
	logic [IdxW-1:0] s_waddr, s_raddr;
	logic [15:0]     s_rdata;
	// sorted magnitudes
	logic            m_we;
	logic [IdxW-1:0] m_waddr, m_raddr;
	logic [MagW-1:0] m_wdata, m_rdata;

	l1bp_pkg::div_req_t div_req;
	logic               div_done;
	logic [SumW-1:0]    div_quo;
	logic               div_go_q;
	l1bp_pkg::div_req_t div_req_eff;

	l1bp_ram #(.Depth(l1bp_pkg::MaxElements), .Width(16)) u_samples (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(sample),
		.raddr(s_raddr), .rdata(s_rdata)
	);
	l1bp_ram #(.Depth(l1bp_pkg::MaxElements), .Width(MagW)) u_sorted (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);
	l1bp_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req_eff), .done(div_done),
		.quotient(div_quo));

	assign busy      = (state_q != l1bp_pkg::ST_LOAD);
	assign cfg_ready = (state_q == l1bp_pkg::ST_LOAD);
	assign accept    = start && !busy;

	// store writes: samples at load, magnitudes also copied unsorted at load
	assign s_we    = accept && (count_q < CntW'(l1bp_pkg::MaxElements));
	assign s_waddr = count_q[IdxW-1:0];

	// scan arithmetic
	logic [SumW-1:0]     sum_nx;
	logic [SumW+CntW:0]  lhs;
	logic                pass;
	assign sum_nx = sum_q + SumW'(m_rdata);
	assign lhs    = (SumW+CntW+1)'(m_rdata) * (SumW+CntW+1)'(i_q + 1'b1);
	assign pass   = (lhs + (SumW+CntW+1)'(radius_q)) > (SumW+CntW+1)'(sum_nx);

	// emission arithmetic
	logic [MagW-1:0]  emag;
	logic [SumW:0]    ediff;
	logic [MagW-1:0]  eclip;
	assign emag  = l1bp_pkg::mag_of(s_rdata);
	assign ediff = (SumW+1)'(emag) - (SumW+1)'(theta_q);
	assign eclip = ediff[SumW] ? '0 : ediff[MagW-1:0];

	// next state and memory control
	always_comb begin
		state_d = state_q;
		m_we    = 1'b0;
		m_waddr = j_q[IdxW-1:0];
		m_wdata = key_q;
		m_raddr = '0;
		s_raddr = i_q[IdxW-1:0];
		div_req = '0;
		if (s_we) begin
			m_we    = 1'b1;
			m_waddr = count_q[IdxW-1:0];
			m_wdata = l1bp_pkg::mag_of(sample);
		end
		unique case (state_q)
			l1bp_pkg::ST_LOAD: begin
				if (accept && end_of_vector) begin
					if (count_q == '0 && !s_we) begin
						state_d = l1bp_pkg::ST_LOAD;
					end else begin
						state_d = l1bp_pkg::ST_SORT_RD;
					end
				end
			end
			l1bp_pkg::ST_SORT_RD: begin
				// fetch the key first, then walk down from j-1
				if (i_q >= count_q) begin
					state_d = l1bp_pkg::ST_SCAN_RD;
				end else if (key_ld_q && j_q == '0) begin
					// key goes to the front
					m_we    = 1'b1;
					m_waddr = j_q[IdxW-1:0];
					m_wdata = key_q;
				end else begin
					m_raddr = key_ld_q ? IdxW'(j_q - 1'b1) : i_q[IdxW-1:0];
					state_d = l1bp_pkg::ST_SORT_CMP;
				end
			end
			l1bp_pkg::ST_SORT_CMP: begin
				// capture the fetched key, else shift the smaller entry up or place the key
				if (key_ld_q) begin
					m_we    = 1'b1;
					m_waddr = j_q[IdxW-1:0];
					m_wdata = (m_rdata < key_q) ? m_rdata : key_q;
				end
				state_d = l1bp_pkg::ST_SORT_RD;
			end
			l1bp_pkg::ST_SCAN_RD: begin
				m_raddr = i_q[IdxW-1:0];
				state_d = l1bp_pkg::ST_SCAN;
			end
			l1bp_pkg::ST_SCAN: begin
				if (!pass || i_q + 1'b1 >= count_q) begin
					state_d = l1bp_pkg::ST_DIV;
				end else begin
					state_d = l1bp_pkg::ST_SCAN_RD;
				end
			end
			l1bp_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = l1bp_pkg::ST_EMIT_RD;
				end
			end
			l1bp_pkg::ST_EMIT_RD: begin
				state_d = l1bp_pkg::ST_EMIT;
			end
			l1bp_pkg::ST_EMIT: begin
				state_d = (i_q + 1'b1 >= count_q) ? l1bp_pkg::ST_LOAD
					: l1bp_pkg::ST_EMIT_RD;
			end
			default: state_d = l1bp_pkg::ST_LOAD;
		endcase
		// divider launch on leaving the scan
		if (state_q == l1bp_pkg::ST_SCAN && state_d == l1bp_pkg::ST_DIV) begin
			div_req.start = 1'b1;
		end
		div_req.divisor = rho_q + 1'b1;
		div_req.dividend = (sum_rho_q > SumW'(radius_q)) ?
			sum_rho_q - SumW'(radius_q) : '0;
	end

	// the rho/sum captured this cycle must feed the divider, so the launch is
	// delayed to the next cycle: handled by a delayed start register
	always_comb begin
		div_req_eff       = div_req;
		div_req_eff.start = div_go_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= l1bp_pkg::ST_LOAD;
			radius_q <= l1bp_pkg::RadiusReset;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			key_ld_q <= 1'b0;
			div_go_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			div_go_q     <= div_req.start;
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				radius_q <= (cfg_data == '0) ? l1bp_pkg::RadiusW'(1) : cfg_data;
			end
			unique case (state_q)
				l1bp_pkg::ST_LOAD: begin
					if (accept) begin
						if (s_we) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (end_of_vector && count_q == '0 && !s_we) begin
							ovf_q <= 1'b0;
						end
						i_q <= CntW'(1);
						j_q <= CntW'(1);
					end
				end
				l1bp_pkg::ST_SORT_RD: begin
					if (i_q >= count_q) begin
						i_q <= '0;
					end else if (key_ld_q && j_q == '0) begin
						i_q      <= i_q + 1'b1;
						j_q      <= i_q + 1'b1;
						key_ld_q <= 1'b0;
					end
				end
				l1bp_pkg::ST_SORT_CMP: begin
					if (!key_ld_q) begin
						key_ld_q <= 1'b1;
					end else if (m_rdata < key_q) begin
						j_q <= j_q - 1'b1;
					end else begin
						i_q      <= i_q + 1'b1;
						j_q      <= i_q + 1'b1;
						key_ld_q <= 1'b0;
					end
				end
				l1bp_pkg::ST_SCAN: begin
					if (pass) begin
						i_q <= i_q + 1'b1;
					end
				end
				l1bp_pkg::ST_DIV: begin
					i_q <= '0;
				end
				l1bp_pkg::ST_EMIT: begin
					result_valid <= 1'b1;
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 >= count_q) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == l1bp_pkg::ST_SORT_CMP && !key_ld_q) begin
			key_q <= m_rdata;
		end
		if (state_q == l1bp_pkg::ST_SORT_RD && i_q >= count_q) begin
			sum_q     <= '0;
			sum_rho_q <= '0;
			rho_q     <= '0;
		end
		if (state_q == l1bp_pkg::ST_SCAN && pass) begin
			sum_q     <= sum_nx;
			rho_q     <= i_q;
			sum_rho_q <= sum_nx;
		end
		if (state_q == l1bp_pkg::ST_DIV && div_done) begin
			theta_q <= div_quo;
		end
		if (state_q == l1bp_pkg::ST_EMIT) begin
			projected  <= s_rdata[15] ? -$signed(eclip[15:0]) : $signed(eclip[15:0]);
			final_item <= (i_q + 1'b1 >= count_q);
			overflowed <= ovf_q;
		end
	end

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_no_strobe_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q) == l1bp_pkg::ST_EMIT)
		else $error("result strobe outside emission");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy)
		else $error("config accepted while busy");
	a_radius_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		radius_q != '0)
		else $error("radius is zero");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(l1bp_pkg::MaxElements))
		else $error("element count beyond capacity");
endmodule
`default_nettype wire

// File: bench/l1bp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l1bp_checker
// Watches the request, result and radius channels of the L1 ball projection
// block, predicts each projected element and compares the results in order.
// ----------------------------------------------------------------------------
module l1bp_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire               busy,
	input  wire signed [15:0] sample,
	input  wire               end_of_vector,
	input  wire               result_valid,
	input  wire signed [15:0] projected,
	input  wire               final_item,
	input  wire               overflowed,
	input  wire               cfg_valid,
	input  wire               cfg_ready,
	input  wire [21:0]        cfg_data,
	output int                fail_count,
	output int                pending,
	output int                result_count
);
	typedef struct {
		logic signed [15:0] value;
		logic               last;
		logic               ovf;
	} proj_t;

	logic [21:0]        ball_radius;
	logic [15:0]        vec_store [l1bp_pkg::MaxElements];
	int                 vec_len;
	logic               vec_dropped;
	proj_t              proj_q [$];

	function automatic int abs_of(input logic [15:0] raw);
		return raw[15] ? 65536 - int'(raw) : int'(raw);
	endfunction

	// sort magnitudes, find threshold, queue the projected vector
	task automatic project_vector();
		int     mags [$];
		longint acc, at_rho, theta, m, b;
		int     rho;
		proj_t  p;
		begin
			b = longint'(ball_radius);
			for (int i = 0; i < vec_len; i++) mags.push_back(abs_of(vec_store[i]));
			mags.rsort();
			acc = 0; rho = 0; at_rho = 0;
			for (int i = 0; i < vec_len; i++) begin
				acc += mags[i];
				if (longint'(mags[i]) * (i + 1) > acc - b) begin
					rho = i; at_rho = acc;
				end else break;
			end
			theta = at_rho - b;
			theta = (theta < 0) ? 0 : theta / (rho + 1);
			for (int i = 0; i < vec_len; i++) begin
				m = abs_of(vec_store[i]) - theta;
				if (m < 0) m = 0;
				p.value = vec_store[i][15] ? 16'(-m) : 16'(m);
				p.last  = (i == vec_len - 1);
				p.ovf   = vec_dropped;
				proj_q.push_back(p);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		proj_t e;
		if (!arst_n) begin
			ball_radius = l1bp_pkg::RadiusReset;
			vec_len = 0; vec_dropped = 0;
			fail_count = 0; result_count = 0;
			proj_q.delete();
		end else begin
			// result check first: a result cannot belong to a request taken now
			if (result_valid) begin
				result_count++;
				if (proj_q.size() == 0) begin
					$display("%0t: unexpected result %0d", $time, projected);
					fail_count++;
				end else begin
					e = proj_q.pop_front();
					if (projected !== e.value || final_item !== e.last
						|| overflowed !== e.ovf) begin
						$display("%0t: mismatch exp %0d/%0b/%0b got %0d/%0b/%0b", $time,
							e.value, e.last, e.ovf, projected, final_item, overflowed);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				ball_radius = (cfg_data == 0) ? 22'd1 : cfg_data;
			if (start && !busy) begin
				if (vec_len < l1bp_pkg::MaxElements) vec_store[vec_len++] = sample;
				else vec_dropped = 1;
				if (end_of_vector) begin
					if (vec_len > 0) project_vector();
					vec_len = 0; vec_dropped = 0;
				end
			end
		end
		pending = proj_q.size();
	end
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives vectors and radius writes into the L1 ball projection block with
// random gaps; the checker predicts and compares, this module gives a verdict.
// ----------------------------------------------------------------------------
module tb_top;
	logic               clk, arst_n, start, end_of_vector, cfg_valid;
	logic signed [15:0] sample;
	logic [21:0]        cfg_data;
	wire                busy, result_valid, final_item, overflowed, cfg_ready;
	wire signed [15:0]  projected;
	int                 fail_count, pending, result_count;
	int                 idle_cycles, request_count, vector_count;
	bit                 no_gaps;

	l1_ball_projection_top dut (.*);
	l1bp_checker chk (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// watchdog: cycles with nothing accepted
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 200000) begin
			$display("FAIL");
			$finish;
		end
	end

	// send one request and wait for it to be taken
	task automatic send(input logic [15:0] s, input logic eov);
		start <= 1; sample <= s; end_of_vector <= eov;
		do @(posedge clk); while (busy);
		request_count++;
		if (eov) vector_count++;
		if (!no_gaps && $urandom_range(3) == 0) begin
			start <= 0;
			repeat ($urandom_range(9, 1)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_radius(input logic [21:0] r);
		wait_idle();
		cfg_valid <= 1; cfg_data <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	// random vector: mostly small, a few near or past capacity
	task automatic rand_vector();
		int len;
		len = ($urandom_range(15) == 0) ? $urandom_range(70, 60) : $urandom_range(8, 1);
		for (int i = 0; i < len; i++) send(rand_sample(), i == len - 1);
	endtask

	initial begin
		arst_n = 0; start = 0; sample = 0; end_of_vector = 0;
		cfg_valid = 0; cfg_data = 0; idle_cycles = 0;
		request_count = 0; vector_count = 0; no_gaps = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: reset radius, extremes, single element, zero radius
		send(16'h8000, 0); send(16'h7fff, 0); send(16'h0000, 0); send(16'h0001, 1);
		send(16'hffff, 1);
		write_radius(22'd0);
		send(16'h8000, 0); send(16'h0100, 1);
		write_radius(22'h3fffff);
		send(16'h8000, 0); send(16'h7fff, 1);
		write_radius(22'd300);
		for (int i = 0; i < 66; i++) send(16'(i * 37 - 1000), i == 65);
		// random part with radius changes
		while (request_count < 320) begin
			if ($urandom_range(6) == 0)
				write_radius($urandom_range(3) == 0 ? 22'($urandom) : 22'($urandom_range(4096)));
			if (request_count > 270) no_gaps = 1;
			rand_vector();
		end
		wait_idle();
		$display("Sent %0d samples in %0d vectors; %0d projected elements checked.",
			request_count, vector_count, result_count);
		if (fail_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
